@@ src/jdc_pkg.sv @@
package jdc_pkg;

  // Calibration length default
  localparam int CAL_SAMPLES_DEF = 40;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int TIME_W   = 32;
  localparam int DB_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Reset values
  localparam logic [SAMPLE_W-1:0] CENTER_RESET = 12'd2048;
  localparam logic [SAMPLE_W-1:0] DZ_FB_RESET  = 12'd400;
  localparam logic [SAMPLE_W-1:0] DZ_LR_RESET  = 12'd180;
  localparam logic [DB_W-1:0]     DEBOUNCE_RESET = 16'd200;

  // Drive command codes
  typedef enum logic [2:0] {
    DRV_HALT  = 3'd0,
    DRV_FWD   = 3'd1,
    DRV_REV   = 3'd2,
    DRV_PORT  = 3'd3,
    DRV_STBD  = 3'd4
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DZ_FB     = 3'd0,
    CFG_DZ_LR     = 3'd1,
    CFG_DEBOUNCE  = 3'd2,
    CFG_SWAP      = 3'd3,
    CFG_INV_LR    = 3'd4,
    CFG_INV_FB    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] dz_fb;
    logic [SAMPLE_W-1:0] dz_lr;
    logic [DB_W-1:0]     debounce;
    logic                swap;
    logic                inv_lr;
    logic                inv_fb;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W-1:0] y;
  } center_t;

  // Calibration tag attached to an accepted item
  typedef struct packed {
    logic is_cal;
    logic is_last;
  } cal_tag_t;

  typedef struct packed {
    cmd_t cmd;
    logic toggled;
    logic mode;
  } res_t;

endpackage

@@ src/jdc_in_if.sv @@
interface jdc_in_if;
  logic                         valid;
  logic                         ready;
  logic [jdc_pkg::SAMPLE_W-1:0] x_sample;
  logic [jdc_pkg::SAMPLE_W-1:0] y_sample;
  logic                         button_level;
  logic [jdc_pkg::TIME_W-1:0]   time_ms;

  modport source (output valid, x_sample, y_sample, button_level, time_ms, input ready);
  modport sink   (input valid, x_sample, y_sample, button_level, time_ms, output ready);
endinterface

@@ src/jdc_out_if.sv @@
interface jdc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] drive_command;
  logic       mode_toggled;
  logic       mode_now;

  modport source (output valid, drive_command, mode_toggled, mode_now, input ready);
  modport sink   (input valid, drive_command, mode_toggled, mode_now, output ready);
endinterface

@@ src/jdc_cal.sv @@
module jdc_cal #(
  parameter int CAL_SAMPLES = jdc_pkg::CAL_SAMPLES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         acc,
  input  logic [jdc_pkg::SAMPLE_W-1:0] x_sample,
  input  logic [jdc_pkg::SAMPLE_W-1:0] y_sample,
  input  logic                         load,
  output jdc_pkg::cal_tag_t            tag,
  output jdc_pkg::center_t             center
);

  localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
  localparam int LOG_N = $clog2(CAL_SAMPLES);
  localparam int SUM_W = jdc_pkg::SAMPLE_W + LOG_N;
  // Reciprocal multiply: exact floor for any sum below 2^SUM_W
  localparam int DIV_SH = SUM_W + LOG_N;
  localparam int MUL_W  = DIV_SH + 1;
  localparam int PROD_W = SUM_W + MUL_W;
  localparam logic [MUL_W-1:0] DIV_MUL =
    MUL_W'(((64'd1 << DIV_SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  sum_x_r, sum_y_r;
  jdc_pkg::center_t  center_r;
  logic [PROD_W-1:0] prod_x, prod_y;

  // Tag of the item offered now, from the count before it
  assign tag.is_cal  = (cnt_r < CNT_W'(CAL_SAMPLES));
  assign tag.is_last = (cnt_r == CNT_W'(CAL_SAMPLES - 1));

  // Sums are final by the time the last calibration item reaches the stage
  assign prod_x = PROD_W'(sum_x_r) * PROD_W'(DIV_MUL);
  assign prod_y = PROD_W'(sum_y_r) * PROD_W'(DIV_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      sum_x_r    <= '0;
      sum_y_r    <= '0;
      center_r.x <= jdc_pkg::CENTER_RESET;
      center_r.y <= jdc_pkg::CENTER_RESET;
    end else begin
      if (acc && tag.is_cal) begin
        cnt_r   <= cnt_r + CNT_W'(1);
        sum_x_r <= sum_x_r + SUM_W'(x_sample);
        sum_y_r <= sum_y_r + SUM_W'(y_sample);
      end
      if (load) begin
        center_r.x <= prod_x[DIV_SH +: jdc_pkg::SAMPLE_W];
        center_r.y <= prod_y[DIV_SH +: jdc_pkg::SAMPLE_W];
      end
    end
  end

  assign center = center_r;

endmodule

@@ src/jdc_cmd.sv @@
module jdc_cmd (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  logic [jdc_pkg::SAMPLE_W-1:0] x_sample,
  input  logic [jdc_pkg::SAMPLE_W-1:0] y_sample,
  input  logic                         button_level,
  input  logic [jdc_pkg::TIME_W-1:0]   time_ms,
  input  jdc_pkg::center_t             center,
  input  jdc_pkg::cfg_t                cfg,
  output jdc_pkg::res_t                res
);

  localparam int OFS_W = jdc_pkg::SAMPLE_W + 1;

  logic                       mode_r, mode_nxt;
  logic                       btn_prev_r;
  logic [jdc_pkg::TIME_W-1:0] last_r;
  logic [jdc_pkg::TIME_W-1:0] elapsed;
  logic                       toggle;
  logic signed [OFS_W-1:0]    dx, dy, lr, fb, lr_sw, fb_sw, dz_fb, dz_lr;
  jdc_pkg::cmd_t              cmd;

  // Debounced falling edge
  assign elapsed  = time_ms - last_r;
  assign toggle   = btn_prev_r && !button_level &&
                    (elapsed > jdc_pkg::TIME_W'(cfg.debounce));
  assign mode_nxt = mode_r ^ toggle;

  // Centered offsets, swap, invert
  assign dx    = $signed({1'b0, x_sample}) - $signed({1'b0, center.x});
  assign dy    = $signed({1'b0, y_sample}) - $signed({1'b0, center.y});
  assign lr_sw = cfg.swap ? dy : dx;
  assign fb_sw = cfg.swap ? dx : dy;
  assign lr    = cfg.inv_lr ? -lr_sw : lr_sw;
  assign fb    = cfg.inv_fb ? -fb_sw : fb_sw;
  assign dz_fb = $signed({1'b0, cfg.dz_fb});
  assign dz_lr = $signed({1'b0, cfg.dz_lr});

  // Deadzone compare on the active axis; halt when the mode toggles
  always_comb begin
    cmd = jdc_pkg::DRV_HALT;
    if (!toggle) begin
      if (mode_r) begin
        if (fb > dz_fb)       cmd = jdc_pkg::DRV_FWD;
        else if (fb < -dz_fb) cmd = jdc_pkg::DRV_REV;
      end else begin
        if (lr > dz_lr)       cmd = jdc_pkg::DRV_STBD;
        else if (lr < -dz_lr) cmd = jdc_pkg::DRV_PORT;
      end
    end
  end

  assign res.cmd     = cmd;
  assign res.toggled = toggle;
  assign res.mode    = mode_nxt;

  // Mode and debounce state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b1;
      btn_prev_r <= 1'b1;
      last_r     <= '0;
    end else if (fire) begin
      mode_r     <= mode_nxt;
      btn_prev_r <= button_level;
      if (toggle) last_r <= time_ms;
    end
  end

endmodule

@@ src/joystick_drive_command.sv @@
// Registered path from item accept to result valid: input register, then result register.
// Throughput: one item per cycle, limited only by result back-pressure.
// The first CAL_SAMPLES items after reset are calibration items and give no result;
// the axis centers load through a constant reciprocal multiply as the last one retires.
// Reset (synchronous, rst_n low): config to defaults, centers 2048, calibration
// restarts, forward/back mode, button released, last toggle time 0, pipeline empty.
module joystick_drive_command #(
  parameter int CAL_SAMPLES = jdc_pkg::CAL_SAMPLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  jdc_in_if.sink                         in_ch,
  jdc_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [jdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jdc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  jdc_pkg::cfg_t     cfg_r;
  jdc_pkg::cal_tag_t tag, tag_r;
  jdc_pkg::center_t  center;
  jdc_pkg::res_t     res, out_res_r;

  logic                         in_vld_r;
  logic [jdc_pkg::SAMPLE_W-1:0] x_r, y_r;
  logic                         btn_r;
  logic [jdc_pkg::TIME_W-1:0]   time_r;
  logic                         out_vld_r;
  logic                         acc, advance, fire;

  // Handshake: calibration items retire without needing the result register
  assign advance     = in_vld_r && (tag_r.is_cal || !out_vld_r || out_ch.ready);
  assign fire        = advance && !tag_r.is_cal;
  assign in_ch.ready = !in_vld_r || advance;
  assign acc         = in_ch.valid && in_ch.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dz_fb    <= jdc_pkg::DZ_FB_RESET;
      cfg_r.dz_lr    <= jdc_pkg::DZ_LR_RESET;
      cfg_r.debounce <= jdc_pkg::DEBOUNCE_RESET;
      cfg_r.swap     <= 1'b1;
      cfg_r.inv_lr   <= 1'b1;
      cfg_r.inv_fb   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jdc_pkg::CFG_DZ_FB:    cfg_r.dz_fb    <= cfg_wdata[jdc_pkg::SAMPLE_W-1:0];
        jdc_pkg::CFG_DZ_LR:    cfg_r.dz_lr    <= cfg_wdata[jdc_pkg::SAMPLE_W-1:0];
        jdc_pkg::CFG_DEBOUNCE: cfg_r.debounce <= cfg_wdata[jdc_pkg::DB_W-1:0];
        jdc_pkg::CFG_SWAP:     cfg_r.swap     <= cfg_wdata[0];
        jdc_pkg::CFG_INV_LR:   cfg_r.inv_lr   <= cfg_wdata[0];
        jdc_pkg::CFG_INV_FB:   cfg_r.inv_fb   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Calibration accumulator and centers
  jdc_cal #(
    .CAL_SAMPLES(CAL_SAMPLES)
  ) u_cal (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .x_sample (in_ch.x_sample),
    .y_sample (in_ch.y_sample),
    .load     (advance && tag_r.is_last),
    .tag      (tag),
    .center   (center)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      x_r    <= in_ch.x_sample;
      y_r    <= in_ch.y_sample;
      btn_r  <= in_ch.button_level;
      time_r <= in_ch.time_ms;
      tag_r  <= tag;
    end
  end

  // Debounce, mode and command logic
  jdc_cmd u_cmd (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .x_sample     (x_r),
    .y_sample     (y_r),
    .button_level (btn_r),
    .time_ms      (time_r),
    .center       (center),
    .cfg          (cfg_r),
    .res          (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.drive_command = out_res_r.cmd;
  assign out_ch.mode_toggled  = out_res_r.toggled;
  assign out_ch.mode_now      = out_res_r.mode;

endmodule

@@ dv/testbench.sv @@
module testbench;

  localparam int SAMPLE_W     = jdc_pkg::SAMPLE_W;
  localparam int TIME_W       = jdc_pkg::TIME_W;
  localparam int CFG_IDX_W    = jdc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W   = jdc_pkg::CFG_DATA_W;
  localparam int CAL_N        = jdc_pkg::CAL_SAMPLES_DEF;
  localparam int NUM_REGS     = 6;
  localparam int PHASE_ITEMS  = 325;
  localparam int STALL_LIMIT  = 5000;
  localparam int SETTLE_WAIT  = 4;
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  jdc_in_if  in_ch();
  jdc_out_if out_ch();

  joystick_drive_command #(.CAL_SAMPLES(CAL_N)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Predictor copy of the block state and its settings
  jdc_pkg::cfg_t       cur_cfg;
  logic [17:0]         sum_x_acc;
  logic [17:0]         sum_y_acc;
  logic [5:0]          cal_seen;
  logic [SAMPLE_W-1:0] ctr_x;
  logic [SAMPLE_W-1:0] ctr_y;
  logic                fb_mode;
  logic                btn_last;
  logic [TIME_W-1:0]   toggle_stamp;
  jdc_pkg::res_t       pending_cmds[$];

  // Stimulus state and counters
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  logic              sent_btn;
  logic [TIME_W-1:0] clock_ms;
  int                mismatches = 0;
  int                items_sent = 0;
  int                results_seen = 0;
  int                toggles_seen = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Command from the centered offsets, given the current mode
  function automatic jdc_pkg::cmd_t steer(input logic [SAMPLE_W-1:0] x,
                                          input logic [SAMPLE_W-1:0] y);
    int dx;
    int dy;
    int lr;
    int fb;
    dx = int'(x) - int'(ctr_x);
    dy = int'(y) - int'(ctr_y);
    lr = cur_cfg.swap ? dy : dx;
    fb = cur_cfg.swap ? dx : dy;
    if (cur_cfg.inv_lr) lr = -lr;
    if (cur_cfg.inv_fb) fb = -fb;
    if (fb_mode) begin
      if (fb > int'(cur_cfg.dz_fb)) return jdc_pkg::DRV_FWD;
      if (fb < -int'(cur_cfg.dz_fb)) return jdc_pkg::DRV_REV;
    end else begin
      if (lr > int'(cur_cfg.dz_lr)) return jdc_pkg::DRV_STBD;
      if (lr < -int'(cur_cfg.dz_lr)) return jdc_pkg::DRV_PORT;
    end
    return jdc_pkg::DRV_HALT;
  endfunction

  // Advance the predictor by one accepted item
  function automatic void predict_drive(input logic [SAMPLE_W-1:0] x,
                                        input logic [SAMPLE_W-1:0] y,
                                        input logic btn, input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] gap;
    jdc_pkg::res_t r;
    // calibration: accumulate, load centers on the last one, no result
    if (cal_seen < CAL_N) begin
      sum_x_acc = sum_x_acc + 18'(x);
      sum_y_acc = sum_y_acc + 18'(y);
      cal_seen  = cal_seen + 6'd1;
      if (cal_seen == CAL_N) begin
        ctr_x = SAMPLE_W'(sum_x_acc / CAL_N);
        ctr_y = SAMPLE_W'(sum_y_acc / CAL_N);
      end
      return;
    end
    gap = t - toggle_stamp;
    r.toggled = btn_last && !btn && (gap > TIME_W'(cur_cfg.debounce));
    if (r.toggled) begin
      fb_mode      = !fb_mode;
      toggle_stamp = t;
      r.cmd        = jdc_pkg::DRV_HALT;
    end else begin
      r.cmd = steer(x, y);
    end
    btn_last = btn;
    r.mode   = fb_mode;
    pending_cmds.push_back(r);
  endfunction

  // Offer one item, with random idle cycles ahead of it
  task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y,
                             input logic btn, input logic [TIME_W-1:0] t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.x_sample     <= x;
    in_ch.y_sample     <= y;
    in_ch.button_level <= btn;
    in_ch.time_ms      <= t;
    do @(posedge clk); while (!in_ch.ready);
    predict_drive(x, y, btn, t);
    sent_btn = btn;
    clock_ms = t;
    items_sent++;
  endtask

  // Hold the input and wait for every expected result
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_cmds.size() != 0);
  endtask

  // Write all registers while the block is idle
  task automatic load_config(input jdc_pkg::cfg_t c);
    jdc_pkg::cfg_idx_t idx;
    logic [CFG_DATA_W-1:0] v;
    wait_drained();
    // calibration items leave no result behind, so let the pipeline empty
    repeat (SETTLE_WAIT) @(posedge clk);
    for (int i = 0; i < NUM_REGS; i++) begin
      idx = jdc_pkg::cfg_idx_t'(i);
      case (idx)
        jdc_pkg::CFG_DZ_FB:    v = CFG_DATA_W'(c.dz_fb);
        jdc_pkg::CFG_DZ_LR:    v = CFG_DATA_W'(c.dz_lr);
        jdc_pkg::CFG_DEBOUNCE: v = CFG_DATA_W'(c.debounce);
        jdc_pkg::CFG_SWAP:     v = CFG_DATA_W'(c.swap);
        jdc_pkg::CFG_INV_LR:   v = CFG_DATA_W'(c.inv_lr);
        jdc_pkg::CFG_INV_FB:   v = CFG_DATA_W'(c.inv_fb);
        default:               v = '0;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= v;
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic jdc_pkg::cfg_t random_cfg();
    jdc_pkg::cfg_t c;
    c.dz_fb    = ($urandom_range(0, 2) == 0) ? 12'($urandom_range(0, 4095))
                                             : 12'($urandom_range(0, 600));
    c.dz_lr    = ($urandom_range(0, 2) == 0) ? 12'($urandom_range(0, 4095))
                                             : 12'($urandom_range(0, 600));
    c.debounce = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(0, 1000));
    c.swap     = 1'($urandom);
    c.inv_lr   = 1'($urandom);
    c.inv_fb   = 1'($urandom);
    return c;
  endfunction

  // Sample value, biased toward the deadzone bounds around a center, the center itself and the rails
  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] center);
    int dz;
    int v;
    dz = $urandom_range(0, 1) ? int'(cur_cfg.dz_fb) : int'(cur_cfg.dz_lr);
    case ($urandom_range(0, 3))
      0:       v = int'($urandom_range(0, 4095));
      1:       v = int'(center) + ($urandom_range(0, 1) ? 1 : -1)
                   * (dz + int'($urandom_range(0, 2)) - 1);
      2:       v = int'(center) + int'($urandom_range(0, 6)) - 3;
      default: v = $urandom_range(0, 1) ? 4095 : 0;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return SAMPLE_W'(v);
  endfunction

  // Button presses with bounce, time stamps near the debounce bound plus some noise
  task automatic send_random_sample();
    logic btn;
    logic [TIME_W-1:0] t;
    btn = ($urandom_range(0, 99) < 30) ? !sent_btn : sent_btn;
    case ($urandom_range(0, 9))
      0, 1:    t = toggle_stamp + TIME_W'(cur_cfg.debounce) + TIME_W'($urandom_range(0, 1));
      8:       t = $urandom;
      9:       t = clock_ms;
      default: t = clock_ms + TIME_W'($urandom_range(0, int'(cur_cfg.debounce) / 2 + 2));
    endcase
    send_sample(pick_sample(ctr_x), pick_sample(ctr_y), btn, t);
  endtask

  task automatic run_random_phase(input jdc_pkg::cfg_t c, input int send_pct,
                                  input int recv_pct);
    load_config(c);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      // sender holds off now and then until the block has answered everything
      if (i == PHASE_ITEMS / 2 || $urandom_range(0, 199) == 0) wait_drained();
      send_random_sample();
    end
  endtask

  // Centers: x alternates 4095/4094, y alternates 0/1, both averages truncate.
  // Button and time are noise here; the last item holds the button down.
  task automatic test_calibration();
    for (int i = 0; i < CAL_N; i++)
      send_sample((i % 2 == 1) ? 12'd4094 : 12'd4095, SAMPLE_W'(i % 2),
                  (i == CAL_N - 1) ? 1'b0 : 1'($urandom), $urandom);
  endtask

  // Reset settings: swapped and inverted axes, deadzones 400/180, debounce 200
  task automatic test_reset_defaults();
    send_sample(12'd2048, 12'd2048, 1'b0, 32'd1000);  // edge against the held release
    send_sample(12'd0,    12'd4095, 1'b1, 32'd1001);
    send_sample(12'd4095, 12'd0,    1'b1, 32'd1002);
    send_sample(12'd4095, 12'd181,  1'b1, 32'd1003);
    send_sample(12'd4095, 12'd180,  1'b1, 32'd1004);
    send_sample(12'd4094, 12'd0,    1'b0, 32'd1100);  // too soon
    send_sample(12'd4094, 12'd0,    1'b1, 32'd1150);
    send_sample(12'd4094, 12'd0,    1'b0, 32'd1200);  // exactly the debounce
    send_sample(12'd4094, 12'd0,    1'b1, 32'd1201);
    send_sample(12'd4094, 12'd0,    1'b0, 32'd1201);  // one past it
    send_sample(12'd0,    12'd0,    1'b0, 32'd5000);  // held low, no edge
    send_sample(12'd4095, 12'd0,    1'b1, 32'd5001);
  endtask

  // All registers zero: plain axes, zero deadzones, toggle needs any time step
  task automatic test_deadzone_edges();
    load_config('{dz_fb: 12'd0, dz_lr: 12'd0, debounce: 16'd0,
                  swap: 1'b0, inv_lr: 1'b0, inv_fb: 1'b0});
    send_sample(12'd4094, 12'd0,    1'b1, 32'd6000);
    send_sample(12'd4094, 12'd1,    1'b1, 32'd6001);
    send_sample(12'd4094, 12'd4095, 1'b1, 32'd6002);
    send_sample(12'd4094, 12'd0,    1'b0, 32'd1201);  // same stamp as last toggle
    send_sample(12'd4094, 12'd0,    1'b1, 32'd1202);
    send_sample(12'd4094, 12'd0,    1'b0, 32'd1202);
    send_sample(12'd4095, 12'd0,    1'b1, 32'd1203);
    send_sample(12'd4094, 12'd0,    1'b1, 32'd1204);
    send_sample(12'd0,    12'd0,    1'b1, 32'd1205);
  endtask

  // All registers at maximum, with the millisecond counter wrapping
  task automatic test_debounce_wrap();
    load_config('{dz_fb: 12'd4095, dz_lr: 12'd4095, debounce: 16'hFFFF,
                  swap: 1'b1, inv_lr: 1'b1, inv_fb: 1'b1});
    send_sample(12'd0, 12'd4095, 1'b1, 32'hFFFF_FF00);
    send_sample(12'd0, 12'd4095, 1'b0, 32'hFFFF_FF00);
    send_sample(12'd0, 12'd4095, 1'b1, 32'h0000_FE00);
    send_sample(12'd0, 12'd4095, 1'b0, 32'h0000_FEFF);  // gap 0xFFFF across the wrap
    send_sample(12'd0, 12'd4095, 1'b1, 32'h0000_FEFF);
    send_sample(12'd0, 12'd4095, 1'b0, 32'h0000_FF00);  // gap 0x10000
    send_sample(12'd0, 12'd4095, 1'b1, 32'h0000_FF01);
  endtask

  task automatic test_random_slow_sink();
    run_random_phase(random_cfg(), 23, 63);
    run_random_phase('{dz_fb: 12'd0, dz_lr: 12'd0, debounce: 16'd0,
                       swap: 1'b0, inv_lr: 1'b0, inv_fb: 1'b0}, 23, 63);
  endtask

  task automatic test_random_slow_source();
    run_random_phase(random_cfg(), 63, 23);
    run_random_phase('{dz_fb: 12'd4095, dz_lr: 12'd4095, debounce: 16'hFFFF,
                       swap: 1'b1, inv_lr: 1'b1, inv_fb: 1'b1}, 63, 23);
  endtask

  task automatic test_random_full_rate();
    run_random_phase(random_cfg(), 0, 0);
    run_random_phase(random_cfg(), 0, 0);
  endtask

  // Result sink stalls
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare each result with the oldest expected command
  always @(posedge clk) begin : check_result
    jdc_pkg::res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_cmds.size() == 0) begin
        report_mismatch("result with nothing expected", out_ch.drive_command, -1);
      end else begin
        want = pending_cmds.pop_front();
        if (want.toggled) toggles_seen++;
        if (out_ch.drive_command !== want.cmd)
          report_mismatch("drive_command", out_ch.drive_command, want.cmd);
        if (out_ch.mode_toggled !== want.toggled)
          report_mismatch("mode_toggled", out_ch.mode_toggled, want.toggled);
        if (out_ch.mode_now !== want.mode)
          report_mismatch("mode_now", out_ch.mode_now, want.mode);
      end
    end
  end

  // Watchdog on cycles without any handshake
  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("[joystick_drive_command] ERROR");
    $finish;
  end

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= jdc_pkg::CFG_DZ_FB;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.x_sample     <= '0;
    in_ch.y_sample     <= '0;
    in_ch.button_level <= 1'b1;
    in_ch.time_ms      <= '0;

    // predictor at its reset state
    cur_cfg      = '{dz_fb: jdc_pkg::DZ_FB_RESET, dz_lr: jdc_pkg::DZ_LR_RESET,
                     debounce: jdc_pkg::DEBOUNCE_RESET,
                     swap: 1'b1, inv_lr: 1'b1, inv_fb: 1'b1};
    sum_x_acc    = '0;
    sum_y_acc    = '0;
    cal_seen     = '0;
    ctr_x        = jdc_pkg::CENTER_RESET;
    ctr_y        = jdc_pkg::CENTER_RESET;
    fb_mode      = 1'b1;
    btn_last     = 1'b1;
    toggle_stamp = '0;
    sent_btn     = 1'b1;
    clock_ms     = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_calibration();
    test_reset_defaults();
    test_deadzone_edges();
    test_debounce_wrap();
    test_random_slow_sink();
    test_random_slow_source();
    test_random_full_rate();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d items (%0d for calibration), checked %0d drive results, %0d toggles",
             items_sent, CAL_N, results_seen, toggles_seen);
    $display("settings: reset, all zero, all maximum and four random; %0d mismatches",
             mismatches);
    if (mismatches == 0)
      $display("[joystick_drive_command] OK");
    else
      $display("[joystick_drive_command] ERROR");
    $finish;
  end

endmodule
